### hdl/tpc_pkg.sv
// types, constants and the duty reciprocal table for the timer pwm counter
// no dependencies; imported by tpc_duty and timer_pwm_counter_unit

package tpc_pkg;

    localparam int CNT_W       = 16;   // main counter and compare width
    localparam int PSC_W       = 16;   // prescaler width
    localparam int CH_W        = 2;    // channel index field width
    localparam int MAX_CH      = 4;    // channels carried by the result item
    localparam int PCT_W       = 8;    // duty percent is the low byte of value
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    // duty scaling: floor(x * pct / 100) as (x * ceil(pct * 2^24 / 100)) >> 24,
    // exact for x up to 2^16 since the rounding error stays below 1/256
    localparam int PCT_SCALE    = 100;
    localparam int RECIP_SHIFT  = 24;
    localparam int RECIP_W      = 24;
    localparam int RECIP_DEPTH  = 128;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_CLR_FLAG = 2'd1,
        OP_DUTY     = 2'd2,
        OP_COMPARE  = 2'd3
    } tpc_op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PRESCALE = 3'd0,
        CFG_RELOAD   = 3'd1,
        CFG_DOWN     = 3'd2,
        CFG_ENABLE   = 3'd3,
        CFG_CH_MASK  = 3'd4
    } tpc_cfg_addr_t;

    typedef struct packed {
        tpc_op_t           opcode;
        logic [CH_W-1:0]   channel;
        logic [CNT_W-1:0]  value;
    } tpc_in_t;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              update_flag;
        logic [MAX_CH-1:0] pwm_out;
    } tpc_out_t;

    typedef logic [RECIP_W-1:0] recip_tab_t [RECIP_DEPTH];

    // entries 1..99 hold ceil(pct * 2^24 / 100); the rest are never used
    function automatic recip_tab_t build_recip();
        recip_tab_t tab;
        longint     num;
        for (int p = 0; p < RECIP_DEPTH; p++) begin
            num = (longint'(p) << RECIP_SHIFT) + longint'(PCT_SCALE - 1);
            if (p > 0 && p < PCT_SCALE) begin
                tab[p] = RECIP_W'(num / PCT_SCALE);
            end else begin
                tab[p] = '0;
            end
        end
        return tab;
    endfunction

    localparam recip_tab_t RECIP_TAB = build_recip();

endpackage

### hdl/tpc_duty.sv
// duty percent to compare value conversion, one multiply by a table reciprocal
// depends on tpc_pkg

module tpc_duty
    import tpc_pkg::*;
(
    input  logic [CNT_W-1:0] reload,
    input  logic [CNT_W-1:0] value,
    output logic [CNT_W-1:0] compare
);

    localparam int PROD_W = CNT_W + 1 + RECIP_W;

    logic [PCT_W-1:0]   pct;
    logic [CNT_W:0]     period;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod;

    assign pct    = value[PCT_W-1:0];
    assign period = {1'b0, reload} + (CNT_W+1)'(1);
    assign recip  = RECIP_TAB[pct[$clog2(RECIP_DEPTH)-1:0]];
    assign prod   = PROD_W'(period) * PROD_W'(recip);

    always_comb begin
        if (pct == '0) begin
            compare = '0;
        end else if (pct >= PCT_W'(PCT_SCALE)) begin
            compare = reload;
        end else begin
            compare = prod[RECIP_SHIFT +: CNT_W];
        end
    end

endmodule

### hdl/timer_pwm_counter_unit.sv
// top level of the timer pwm counter: prescaler, up/down counter, compares
// depends on tpc_pkg and tpc_duty
//
//  channel  | ports                            | payload
//  ---------+----------------------------------+---------------------------
//  input    | s_valid  s_ready  s_data         | tpc_in_t  opcode/channel/value
//  result   | m_valid  m_ready  m_data         | tpc_out_t count/flag/pwm_out
//  config   | cfg_valid cfg_ready cfg_addr ... | register index, write data
//
// one item per cycle sustained while m_ready is high; an accepted item goes to
// the input register, then the result register: the input register feeds one pass
// of logic (tick, flag clear, compare write or duty multiply, then pwm compares)
// reset: synchronous active-low aresetn; counter, prescaler, flag and all
// compares go to zero, reload to all ones, the rest but the payload registers to zero
// stalls: while m_ready is low the result register holds, the input register
// fills, and s_ready drops only when both are occupied

module timer_pwm_counter_unit
    import tpc_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
)(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  tpc_in_t               s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output tpc_out_t              m_data,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [PSC_W-1:0]        prescale_reg, prescale_next;
    logic [CNT_W-1:0]        reload_reg,   reload_next;
    logic                    down_reg,     down_next;
    logic                    enable_reg,   enable_next;
    logic [MAX_CH-1:0]       ch_mask_reg,  ch_mask_next;

    // timer state
    logic [PSC_W-1:0]        psc_cnt_reg,  psc_cnt_next;
    logic [CNT_W-1:0]        count_reg,    count_next;
    logic                    flag_reg,     flag_next;
    logic [CNT_W-1:0]        preload_reg [NUM_CHANNELS];
    logic [CNT_W-1:0]        preload_next[NUM_CHANNELS];
    logic [CNT_W-1:0]        active_reg  [NUM_CHANNELS];
    logic [CNT_W-1:0]        active_next [NUM_CHANNELS];

    // input and result stages
    tpc_in_t                 in_reg;
    logic                    in_valid_reg, in_valid_next;
    tpc_out_t                out_reg,      out_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    s_accept;
    logic                    advance;
    logic                    update_evt;
    logic [CNT_W-1:0]        duty_cmp;
    logic [MAX_CH-1:0]       pwm;

    // the item in the input register moves on whenever the result slot frees
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    tpc_duty u_duty (
        .reload  (reload_reg),
        .value   (in_reg.value),
        .compare (duty_cmp)
    );

    // configuration writes: user must issue only while idle; block does not enforce
    always_comb begin
        prescale_next = prescale_reg;
        reload_next   = reload_reg;
        down_next     = down_reg;
        enable_next   = enable_reg;
        ch_mask_next  = ch_mask_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_PRESCALE: prescale_next = cfg_data[PSC_W-1:0];
                CFG_RELOAD:   reload_next   = cfg_data[CNT_W-1:0];
                CFG_DOWN:     down_next     = cfg_data[0];
                CFG_ENABLE:   enable_next   = cfg_data[0];
                CFG_CH_MASK:  ch_mask_next  = cfg_data[MAX_CH-1:0];
                default:      ;   // indexes past the register list are dropped
            endcase
        end
    end

    // single pass over the item held in the input register
    always_comb begin
        psc_cnt_next = psc_cnt_reg;
        count_next   = count_reg;
        flag_next    = flag_reg;
        update_evt   = 1'b0;
        preload_next = preload_reg;
        active_next  = active_reg;

        if (advance) begin
            case (in_reg.opcode)
                OP_TICK: begin
                    if (enable_reg) begin
                        if (psc_cnt_reg >= prescale_reg) begin
                            psc_cnt_next = '0;
                            if (down_reg) begin
                                // down: reload at zero; above reload just decrements
                                if (count_reg == '0) begin
                                    count_next = reload_reg;
                                    update_evt = 1'b1;
                                end else begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end else begin
                                // up: wrap at or above reload
                                if (count_reg >= reload_reg) begin
                                    count_next = '0;
                                    update_evt = 1'b1;
                                end else begin
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                        end else begin
                            psc_cnt_next = psc_cnt_reg + PSC_W'(1);
                        end
                    end
                end
                OP_CLR_FLAG: begin
                    flag_next = 1'b0;
                end
                OP_DUTY, OP_COMPARE: begin
                    // channel indexes with no channel behind them match nothing
                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                        if (in_reg.channel == CH_W'(i)) begin
                            preload_next[i] = (in_reg.opcode == OP_DUTY) ?
                                              duty_cmp : in_reg.value;
                        end
                    end
                end
                default: ;
            endcase

            // update event: sticky flag and preload transfer
            if (update_evt) begin
                flag_next   = 1'b1;
                active_next = preload_reg;
            end
        end
    end

    // pwm mode 1: high while the channel mask bit is set and the count is below the active compare
    always_comb begin
        pwm = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            pwm[i] = ch_mask_reg[i] && (count_next < active_next[i]);
        end
    end

    always_comb begin
        out_next = out_reg;
        if (advance) begin
            out_next.count       = count_next;
            out_next.update_flag = flag_next;
            out_next.pwm_out     = pwm;
        end
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance  ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg  <= '0;
            reload_reg    <= '1;
            down_reg      <= 1'b0;
            enable_reg    <= 1'b0;
            ch_mask_reg   <= '0;
            psc_cnt_reg   <= '0;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                preload_reg[i] <= '0;
                active_reg[i]  <= '0;
            end
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            prescale_reg  <= prescale_next;
            reload_reg    <= reload_next;
            down_reg      <= down_next;
            enable_reg    <= enable_next;
            ch_mask_reg   <= ch_mask_next;
            psc_cnt_reg   <= psc_cnt_next;
            count_reg     <= count_next;
            flag_reg      <= flag_next;
            preload_reg   <= preload_next;
            active_reg    <= active_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= s_data;
        end
        out_reg <= out_next;
    end

endmodule
